>>> rtl/tmap_pkg.sv
// Shared types and constants for the tempo map position-to-time block.
package tmap_pkg;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_FIN = 2'd2,
    OP_QRY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // Divider geometry: span products are 56 bits, tempo is 18 bits
  localparam int DVD_W = 56;
  localparam int DVS_W = 18;

  typedef struct packed {
    logic    latch;
    logic    set_base;
    logic    div_pos;
    logic    pos_make;
    logic    k_init;
    logic    rd;
    logic    shift_wr;
    logic    ins_wr;
    logic    k_dec;
    logic    seg_rd;
    logic    mul;
    logic    div_span;
    logic    span_done;
    logic    out;
    status_t code;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    sub_zero;
    logic    tempo_zero;
    logic    base_zero;
    logic    n_full;
    logic    k_zero;
    logic    k_end;
    logic    loc_gt;
    logic    seg_tempo_zero;
    logic    div_done;
  } sts_t;

endpackage

>>> rtl/tmap_div.sv
// Restoring divider, one quotient bit per cycle.
module tmap_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tmap_pkg::DVD_W-1:0] dividend,
  input  logic [tmap_pkg::DVS_W-1:0] divisor,
  output logic [tmap_pkg::DVD_W-1:0] quotient,
  output logic                       done
);

  localparam int CNT_W = $clog2(tmap_pkg::DVD_W + 1);

  logic [tmap_pkg::DVD_W-1:0] dvd;
  logic [tmap_pkg::DVS_W-1:0] dvs;
  logic [tmap_pkg::DVS_W:0]   rem;
  logic [CNT_W-1:0]           cnt;
  logic                       run;
  logic [tmap_pkg::DVS_W:0]   rem_sh;
  logic                       ge;

  assign rem_sh   = {rem[tmap_pkg::DVS_W-1:0], dvd[tmap_pkg::DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(tmap_pkg::DVD_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (run) begin
      rem <= ge ? rem_sh - {1'b0, dvs} : rem_sh;
      dvd <= {dvd[tmap_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

>>> rtl/tmap_ctrl.sv
// Sequencer for set, insert, finalise and query words.
module tmap_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tmap_pkg::sts_t sts,
  output tmap_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DISP = 10'b0000000010,
    S_POS  = 10'b0000000100,
    S_SCAN = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_MUL  = 10'b0000100000,
    S_SPAN = 10'b0001000000,
    S_WAIT = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    cmd.code   = tmap_pkg::ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          tmap_pkg::OP_SET: begin
            cmd.out = 1'b1;
            if (sts.tempo_zero) cmd.code = tmap_pkg::ST_ZERO;
            else                cmd.set_base = 1'b1;
            state_next = S_IDLE;
          end
          tmap_pkg::OP_ADD: begin
            if (sts.sub_zero || sts.tempo_zero) begin
              cmd.out = 1'b1; cmd.code = tmap_pkg::ST_ZERO; state_next = S_IDLE;
            end else if (sts.n_full) begin
              cmd.out = 1'b1; cmd.code = tmap_pkg::ST_FULL; state_next = S_IDLE;
            end else begin
              cmd.div_pos = 1'b1; state_next = S_POS;
            end
          end
          tmap_pkg::OP_FIN: begin
            if (sts.base_zero) begin
              cmd.out = 1'b1; cmd.code = tmap_pkg::ST_ZERO; state_next = S_IDLE;
            end else begin
              cmd.k_init = 1'b1; state_next = S_FIN;
            end
          end
          default: begin
            if (sts.sub_zero) begin
              cmd.out = 1'b1; cmd.code = tmap_pkg::ST_ZERO; state_next = S_IDLE;
            end else begin
              cmd.div_pos = 1'b1; state_next = S_POS;
            end
          end
        endcase
      end
      S_POS: begin
        if (sts.div_done) begin
          cmd.pos_make = 1'b1;
          cmd.k_init   = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.k_zero) begin
          if (sts.op == tmap_pkg::OP_ADD) begin
            cmd.ins_wr = 1'b1; cmd.out = 1'b1; state_next = S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end else begin
          cmd.rd = 1'b1; state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.loc_gt) begin
          if (sts.op == tmap_pkg::OP_ADD) cmd.shift_wr = 1'b1;
          else                            cmd.k_dec = 1'b1;
          state_next = S_SCAN;
        end else if (sts.op == tmap_pkg::OP_ADD) begin
          cmd.ins_wr = 1'b1; cmd.out = 1'b1; state_next = S_IDLE;
        end else begin
          cmd.seg_rd = 1'b1; state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.seg_tempo_zero) begin
          cmd.out = 1'b1; cmd.code = tmap_pkg::ST_ZERO; state_next = S_IDLE;
        end else begin
          cmd.mul = 1'b1; state_next = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.div_span = 1'b1;
        state_next   = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.span_done = 1'b1;
          state_next    = (sts.op == tmap_pkg::OP_FIN) ? S_FIN : S_DONE;
        end
      end
      S_FIN: begin
        if (sts.k_end) begin
          cmd.out = 1'b1; state_next = S_IDLE;
        end else begin
          cmd.rd = 1'b1; state_next = S_MUL;
        end
      end
      S_DONE: begin
        cmd.out    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/tmap_dp.sv
// Datapath: per-track maps, change memories, span multiplier and divider.
module tmap_dp #(
  parameter int TRACKS      = 4,
  parameter int MAX_CHANGES = 16,
  parameter int BAR_SCALE   = 240
) (
  input  logic           clk,
  input  logic           rst,
  input  tmap_pkg::cmd_t cmd,
  output tmap_pkg::sts_t sts,
  input  logic [1:0]     opcode,
  input  logic [1:0]     track,
  input  logic [15:0]    bar,
  input  logic [7:0]     beat_pos,
  input  logic [8:0]     subdivision,
  input  logic [17:0]    tempo,
  input  logic [31:0]    start_offset,
  output logic           done,
  output logic [31:0]    event_time,
  output logic [1:0]     status
);

  localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int IW    = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;
  localparam int CW    = $clog2(MAX_CHANGES + 1);
  localparam int DEPTH = TRACKS * MAX_CHANGES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [15:0] BS = BAR_SCALE[15:0];

  // latched word
  tmap_pkg::opcode_t lat_op;
  logic [TW-1:0]     lat_trk;
  logic [15:0]       lat_bar;
  logic [7:0]        lat_beat;
  logic [8:0]        lat_sub;
  logic [17:0]       lat_tempo;
  logic [31:0]       lat_off;
  logic [6:0]        trk_mod;

  // per-track state
  logic [17:0]   base_tempo   [TRACKS];
  logic [31:0]   first_offset [TRACKS];
  logic [CW-1:0] change_count [TRACKS];

  // change memories
  logic [31:0] mem_loc   [DEPTH];
  logic [17:0] mem_tempo [DEPTH];
  logic [31:0] mem_time  [DEPTH];
  logic [31:0] rd_loc, rd_time;
  logic [17:0] rd_tempo;

  logic [CW-1:0] k, n;
  logic [IW-1:0] rd_idx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_loc, wr_time;
  logic [17:0]   wr_tempo;

  logic [31:0] pos, seg_origin, seg_start, result, delta;
  logic [17:0] seg_tempo;
  logic        sat;
  logic [tmap_pkg::DVD_W-1:0] prod, div_dvd, quot;
  logic [tmap_pkg::DVS_W-1:0] div_dvs;
  logic        div_done;
  logic [32:0] pos_sum;
  logic [56:0] span_sum;
  logic [31:0] span_clamp;
  logic        fin;

  // track modulo TRACKS; track is below 4, so three conditional subtracts do
  always_comb begin
    trk_mod = 7'(track);
    for (int i = 0; i < 3; i++) begin
      if (trk_mod >= 7'(TRACKS)) trk_mod = trk_mod - 7'(TRACKS);
    end
  end

  assign fin     = lat_op == tmap_pkg::OP_FIN;
  assign n       = change_count[lat_trk];

  assign rd_idx  = fin ? k[IW-1:0] : IW'(k - 1'b1);
  assign rd_addr = AW'(32'(lat_trk) * 32'(MAX_CHANGES) + 32'(rd_idx));
  assign wr_addr = AW'(32'(lat_trk) * 32'(MAX_CHANGES) + 32'(k[IW-1:0]));

  assign pos_sum    = 33'({lat_bar, 16'h0000}) + 33'(quot[23:0]);
  assign span_sum   = 57'(seg_start) + 57'(quot);
  assign span_clamp = (|span_sum[56:32]) ? 32'hFFFF_FFFF : span_sum[31:0];
  assign delta      = (fin ? rd_loc : pos) - seg_origin;

  always_comb begin
    wr_en    = cmd.shift_wr | cmd.ins_wr | (cmd.span_done & fin);
    wr_loc   = rd_loc;
    wr_tempo = rd_tempo;
    wr_time  = rd_time;
    if (cmd.ins_wr) begin
      wr_loc = pos; wr_tempo = lat_tempo; wr_time = '0;
    end else if (cmd.span_done) begin
      wr_time = span_clamp;
    end
  end

  always_comb begin
    if (cmd.div_pos) begin
      div_dvd = tmap_pkg::DVD_W'({lat_beat, 16'h0000});
      div_dvs = tmap_pkg::DVS_W'(lat_sub);
    end else begin
      div_dvd = prod;
      div_dvs = seg_tempo;
    end
  end

  tmap_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_pos | cmd.div_span),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_op    <= tmap_pkg::opcode_t'(opcode);
      lat_trk   <= trk_mod[TW-1:0];
      lat_bar   <= bar;
      lat_beat  <= beat_pos;
      lat_sub   <= subdivision;
      lat_tempo <= tempo;
      lat_off   <= start_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKS; i++) begin
        base_tempo[i]   <= '0;
        first_offset[i] <= '0;
        change_count[i] <= '0;
      end
    end else if (cmd.set_base) begin
      base_tempo[lat_trk]   <= lat_tempo;
      first_offset[lat_trk] <= lat_off;
      change_count[lat_trk] <= '0;
    end else if (cmd.ins_wr) begin
      change_count[lat_trk] <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_loc[wr_addr]   <= wr_loc;
      mem_tempo[wr_addr] <= wr_tempo;
      mem_time[wr_addr]  <= wr_time;
    end
    if (cmd.rd) begin
      rd_loc   <= mem_loc[rd_addr];
      rd_tempo <= mem_tempo[rd_addr];
      rd_time  <= mem_time[rd_addr];
    end
  end

  // scan index and segment registers
  always_ff @(posedge clk) begin
    if (cmd.k_init) begin
      k          <= fin ? '0 : n;
      seg_origin <= '0;
      seg_tempo  <= base_tempo[lat_trk];
      seg_start  <= first_offset[lat_trk];
    end else if (cmd.shift_wr || cmd.k_dec) begin
      k <= k - 1'b1;
    end else if (cmd.seg_rd) begin
      seg_origin <= rd_loc;
      seg_tempo  <= rd_tempo;
      seg_start  <= rd_time;
    end else if (cmd.span_done && fin) begin
      k          <= k + 1'b1;
      seg_origin <= rd_loc;
      seg_tempo  <= rd_tempo;
      seg_start  <= span_clamp;
    end
    if (cmd.pos_make)
      pos <= pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
    if (cmd.mul)
      prod <= {48'(delta) * 48'(BS), 8'h00};
    if (cmd.latch)
      result <= '0;
    else if (cmd.span_done && !fin)
      result <= span_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (cmd.latch) begin
      sat <= 1'b0;
    end else if ((cmd.pos_make && pos_sum[32]) || (cmd.span_done && |span_sum[56:32])) begin
      sat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out) begin
      status     <= (cmd.code == tmap_pkg::ST_OK && sat) ? tmap_pkg::ST_SAT : cmd.code;
      event_time <= (lat_op == tmap_pkg::OP_QRY && cmd.code == tmap_pkg::ST_OK) ? result : '0;
    end
  end

  always_comb begin
    sts                = '0;
    sts.op             = lat_op;
    sts.sub_zero       = lat_sub == '0;
    sts.tempo_zero     = lat_tempo == '0;
    sts.base_zero      = base_tempo[lat_trk] == '0;
    sts.n_full         = n >= CW'(MAX_CHANGES);
    sts.k_zero         = k == '0;
    sts.k_end          = k == n;
    sts.loc_gt         = rd_loc > pos;
    sts.seg_tempo_zero = seg_tempo == '0;
    sts.div_done       = div_done;
  end

endmodule

>>> rtl/tempo_map_position_to_time_top.sv
// Top level of the tempo map position-to-time converter.
//
// Command channel: a word (opcode, track, bar, beat_pos, subdivision, tempo,
// start_offset) is taken at a rising edge with start high and busy low.
// Each word gives one result word: done pulses for one cycle with
// event_time and status valid; the receiver cannot stall, so take it then.
// Opcodes: set base and clear, add change, finalise, query.
// Set base and errors caught at dispatch answer straight from the dispatch state.
// Add divides the position, then moves each later change up one place and
// writes the new one. Query divides the position, scans back to its segment,
// multiplies the span and divides it; a zero base tempo ends it before the
// multiply. Finalise multiplies and divides once per stored change. The shared
// restoring divider (one quotient bit a cycle over 56 bits) serves every divide.
// One word is in flight at a time; busy drops with the done strobe, so the
// next word can be taken at the edge that takes the result.
// Reset clears all track maps (base tempo, offset, change count); the change
// memories need no clearing as only entries below the count are read.
module tempo_map_position_to_time_top #(
  parameter int TRACKS      = 4,
  parameter int MAX_CHANGES = 16,
  parameter int BAR_SCALE   = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [1:0]  track,
  input  logic [15:0] bar,
  input  logic [7:0]  beat_pos,
  input  logic [8:0]  subdivision,
  input  logic [17:0] tempo,
  input  logic [31:0] start_offset,
  output logic        done,
  output logic [31:0] event_time,
  output logic [1:0]  status
);

  tmap_pkg::cmd_t cmd;
  tmap_pkg::sts_t sts;

  tmap_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tmap_dp #(
    .TRACKS      (TRACKS),
    .MAX_CHANGES (MAX_CHANGES),
    .BAR_SCALE   (BAR_SCALE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .track        (track),
    .bar          (bar),
    .beat_pos     (beat_pos),
    .subdivision  (subdivision),
    .tempo        (tempo),
    .start_offset (start_offset),
    .done         (done),
    .event_time   (event_time),
    .status       (status)
  );

endmodule

>>> tb/sv/tb_tempo_map_position_to_time_top.sv
// Testbench for the tempo map position-to-time block: predictor, driver and monitor.
`timescale 1ns / 100ps

module tb_tempo_map_position_to_time_top;

  localparam int TRACKS      = 4;
  localparam int MAX_CHANGES = 16;
  localparam int BAR_SCALE   = 240;
  localparam logic [32:0] SAT_LIMIT = 33'h0_FFFF_FFFF;

  // One command word as driven on the ports
  typedef struct packed {
    tmap_pkg::opcode_t op;
    logic [1:0]        trk;
    logic [15:0]       bar;
    logic [7:0]        beat;
    logic [8:0]        sub;
    logic [17:0]       tempo;
    logic [31:0]       offset;
  } word_t;

  typedef struct packed {
    logic [31:0]       time_s;
    tmap_pkg::status_t code;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [1:0]  track;
  logic [15:0] bar;
  logic [7:0]  beat_pos;
  logic [8:0]  subdivision;
  logic [17:0] tempo;
  logic [31:0] start_offset;
  logic        done;
  logic [31:0] event_time;
  logic [1:0]  status;

  tempo_map_position_to_time_top #(
    .TRACKS(TRACKS), .MAX_CHANGES(MAX_CHANGES), .BAR_SCALE(BAR_SCALE)
  ) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .track(track), .bar(bar), .beat_pos(beat_pos), .subdivision(subdivision),
    .tempo(tempo), .start_offset(start_offset), .done(done),
    .event_time(event_time), .status(status)
  );

  // Predictor state: one tempo map per track
  logic [17:0] map_base_tempo [TRACKS];
  logic [31:0] map_offset     [TRACKS];
  int          map_count      [TRACKS];
  logic [31:0] map_loc   [TRACKS][MAX_CHANGES];
  logic [17:0] map_tempo [TRACKS][MAX_CHANGES];
  logic [31:0] map_time  [TRACKS][MAX_CHANGES];

  word_t   pending_words [$];
  answer_t expected_answers [$];
  int      error_count;
  int      send_idle_pct;
  bit      hold_send;
  bit      stim_done;
  logic    busy_at_rise;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fail-safe: even ~1950 words of the slowest kind, finalise, end well under this
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic add_word(input word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic logic [31:0] clamp_time(input logic [63:0] v, inout bit sat);
    if (v > 64'(SAT_LIMIT)) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Bars Q16.16 from bar + beat/sub; sub is non-zero
  function automatic logic [31:0] bar_position(input word_t w, inout bit sat);
    logic [63:0] frac;
    frac = ({40'd0, w.beat, 16'd0}) / {55'd0, w.sub};
    return clamp_time({32'd0, w.bar, 16'd0} + frac, sat);
  endfunction

  function automatic logic [63:0] span_seconds(input logic [31:0] d, input logic [17:0] t);
    return ({32'd0, d} * 64'(BAR_SCALE) * 64'd256) / {46'd0, t};
  endfunction

  function automatic answer_t predict_answer(input word_t w);
    answer_t a;
    bit sat;
    int t, n, k;
    logic [31:0] pos, origin, st;
    logic [17:0] seg_t;
    a = '{time_s: '0, code: tmap_pkg::ST_OK};
    sat = 1'b0;
    t = int'(w.trk) % TRACKS;
    n = map_count[t];
    case (w.op)
      tmap_pkg::OP_SET: begin
        if (w.tempo == 0) a.code = tmap_pkg::ST_ZERO;
        else begin
          map_base_tempo[t] = w.tempo;
          map_offset[t] = w.offset;
          map_count[t] = 0;
        end
      end
      tmap_pkg::OP_ADD: begin
        if (w.sub == 0 || w.tempo == 0) a.code = tmap_pkg::ST_ZERO;
        else if (n >= MAX_CHANGES) a.code = tmap_pkg::ST_FULL;
        else begin
          pos = bar_position(w, sat);
          k = n;
          while (k > 0 && map_loc[t][k-1] > pos) begin
            map_loc[t][k] = map_loc[t][k-1];
            map_tempo[t][k] = map_tempo[t][k-1];
            map_time[t][k] = map_time[t][k-1];
            k--;
          end
          map_loc[t][k] = pos;
          map_tempo[t][k] = w.tempo;
          map_time[t][k] = '0;
          map_count[t] = n + 1;
          if (sat) a.code = tmap_pkg::ST_SAT;
        end
      end
      tmap_pkg::OP_FIN: begin
        if (map_base_tempo[t] == 0) a.code = tmap_pkg::ST_ZERO;
        else begin
          for (int i = 0; i < n; i++) begin
            if (i == 0)
              map_time[t][0] = clamp_time({32'd0, map_offset[t]} +
                  span_seconds(map_loc[t][0], map_base_tempo[t]), sat);
            else
              map_time[t][i] = clamp_time({32'd0, map_time[t][i-1]} +
                  span_seconds(map_loc[t][i] - map_loc[t][i-1], map_tempo[t][i-1]), sat);
          end
          if (sat) a.code = tmap_pkg::ST_SAT;
        end
      end
      default: begin
        if (w.sub == 0) a.code = tmap_pkg::ST_ZERO;
        else begin
          pos = bar_position(w, sat);
          k = n;
          while (k > 0 && map_loc[t][k-1] > pos) k--;
          if (k == 0) begin
            seg_t = map_base_tempo[t]; origin = '0; st = map_offset[t];
          end else begin
            seg_t = map_tempo[t][k-1]; origin = map_loc[t][k-1]; st = map_time[t][k-1];
          end
          if (seg_t == 0) a.code = tmap_pkg::ST_ZERO;
          else begin
            a.time_s = clamp_time({32'd0, st} + span_seconds(pos - origin, seg_t), sat);
            if (sat) a.code = tmap_pkg::ST_SAT;
          end
        end
      end
    endcase
    return a;
  endfunction

  // Driver: offers the next word at the falling edge, drops start once taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_at_rise) begin
      // word was taken at the last rising edge: pop it, maybe offer the next
      if (pending_words.size() > 1 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        void'(pending_words.pop_front());
        drive_word(pending_words[0]);
      end else begin
        void'(pending_words.pop_front());
        start <= 1'b0;
      end
    end else if (!start && pending_words.size() > 0 && !hold_send &&
                 $urandom_range(99) >= send_idle_pct) begin
      drive_word(pending_words[0]);
      start <= 1'b1;
    end
  end

  task automatic drive_word(input word_t w);
    opcode       <= w.op;
    track        <= w.trk;
    bar          <= w.bar;
    beat_pos     <= w.beat;
    subdivision  <= w.sub;
    tempo        <= w.tempo;
    start_offset <= w.offset;
  endtask

  // Acceptance seen at the rising edge; the predictor runs in step with the block
  always @(posedge clk) begin
    busy_at_rise <= !(!rst && start && !busy);
    if (!rst && start && !busy) begin
      expected_answers.insert(expected_answers.size(),
          predict_answer(word_t'{tmap_pkg::opcode_t'(opcode), track, bar,
          beat_pos, subdivision, tempo, start_offset}));
    end
  end

  // Monitor: every strobed word is checked against the oldest prediction
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_a = expected_answers.pop_front();
        if (event_time !== exp_a.time_s)
          report_mismatch($sformatf("event_time %h, expected %h", event_time, exp_a.time_s));
        if (status !== exp_a.code)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_a.code));
      end
    end
  end

  function automatic word_t make_word(input tmap_pkg::opcode_t op, input logic [1:0] trk,
      input logic [15:0] b, input logic [7:0] bt, input logic [8:0] s,
      input logic [17:0] tp, input logic [31:0] off);
    return '{op, trk, b, bt, s, tp, off};
  endfunction

  // Random word; fields mostly well-formed, with some zero and extreme values
  function automatic word_t random_word();
    word_t w;
    int r;
    w.op     = tmap_pkg::opcode_t'($urandom_range(3));
    w.trk    = 2'($urandom);
    r = $urandom_range(9);
    w.bar    = (r < 6) ? 16'($urandom_range(64)) : (r < 8 ? 16'($urandom) : 16'hFFFF);
    w.beat   = 8'($urandom);
    r = $urandom_range(19);
    w.sub    = (r == 0) ? 9'd0 : (r == 1 ? 9'd256 : 9'($urandom_range(1, 256)));
    r = $urandom_range(19);
    w.tempo  = (r == 0) ? 18'd0 : (r == 1 ? 18'h3FFFF :
               (r < 4 ? 18'($urandom_range(1, 255)) : 18'($urandom_range(60 << 8, 200 << 8))));
    w.offset = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 1 << 20));
    return w;
  endfunction

  task automatic queue_random_words(input int count);
    int added;
    word_t w;
    added = 0;
    while (added < count) begin
      if ($urandom_range(3) != 0) begin
        // a whole sequence: set, several adds, finalise, queries
        w = random_word();
        w.op = tmap_pkg::OP_SET;
        if (w.tempo == 0) w.tempo = 18'd30720;
        add_word(w);
        for (int i = $urandom_range(0, 18); i > 0; i--) begin
          w = random_word(); w.op = tmap_pkg::OP_ADD; add_word(w); added++;
        end
        w.op = tmap_pkg::OP_FIN; add_word(w);
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          w = random_word(); w.op = tmap_pkg::OP_QRY; add_word(w); added++;
        end
        added += 2;
      end else begin
        add_word(random_word());
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_answers.size() > 0 || start)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; busy_at_rise = 1'b1;
    opcode = tmap_pkg::OP_SET; track = '0; bar = '0; beat_pos = '0; subdivision = '0;
    tempo = '0; start_offset = '0;
    error_count = 0; send_idle_pct = 0; hold_send = 1'b0; stim_done = 1'b0;
    for (int i = 0; i < TRACKS; i++) begin
      map_base_tempo[i] = '0;
      map_offset[i]     = '0;
      map_count[i]      = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: zero base before any set, zero fields, extremes, full list,
    // equal positions, stale times, saturation of position and time
    add_word(make_word(tmap_pkg::OP_QRY, 2'd0, 16'd1, 8'd0, 9'd4, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_FIN, 2'd1, 16'd0, 8'd0, 9'd4, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_SET, 2'd0, 16'd0, 8'd0, 9'd4, 18'd0, 32'd5));
    add_word(make_word(tmap_pkg::OP_SET, 2'd0, 16'd0, 8'd0, 9'd4, 18'd30720, 32'd5));
    add_word(make_word(tmap_pkg::OP_ADD, 2'd0, 16'd4, 8'd2, 9'd0, 18'd100, 32'd0));
    add_word(make_word(tmap_pkg::OP_ADD, 2'd0, 16'd4, 8'd2, 9'd4, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_ADD, 2'd0, 16'd8, 8'd0, 9'd4, 18'd40000, 32'd0));
    add_word(make_word(tmap_pkg::OP_ADD, 2'd0, 16'd4, 8'd2, 9'd4, 18'd20000, 32'd0));
    add_word(make_word(tmap_pkg::OP_ADD, 2'd0, 16'd4, 8'd2, 9'd4, 18'd25000, 32'd0));
    add_word(make_word(tmap_pkg::OP_QRY, 2'd0, 16'd4, 8'd2, 9'd4, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_FIN, 2'd0, 16'd0, 8'd0, 9'd4, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_QRY, 2'd0, 16'd4, 8'd2, 9'd4, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_QRY, 2'd0, 16'd2, 8'd1, 9'd0, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_ADD, 2'd0, 16'hFFFF, 8'hFF, 9'd1, 18'h3FFFF, 32'd0));
    add_word(make_word(tmap_pkg::OP_QRY, 2'd0, 16'hFFFF, 8'hFF, 9'd1, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_SET, 2'd3, 16'd0, 8'd0, 9'd1, 18'd1, 32'hFFFF_FFFF));
    for (int i = 0; i < MAX_CHANGES + 1; i++)
      add_word(make_word(tmap_pkg::OP_ADD, 2'd3, 16'(i * 4000), 8'd0, 9'd256,
          18'd1, 32'd0));
    add_word(make_word(tmap_pkg::OP_FIN, 2'd3, 16'd0, 8'd0, 9'd1, 18'd0, 32'd0));
    add_word(make_word(tmap_pkg::OP_QRY, 2'd3, 16'hFFFF, 8'd255, 9'd256, 18'd0, 32'd0));
    wait_drained();

    // Random phases: sender idles 28 %, then 68 %, then never
    send_idle_pct = 28;
    queue_random_words(640);
    // Pause until every expected result has come
    while (pending_words.size() > 200) @(posedge clk);
    hold_send = 1'b1;
    while (expected_answers.size() > 0 || start) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();
    send_idle_pct = 68;
    queue_random_words(630);
    wait_drained();
    send_idle_pct = 0;
    queue_random_words(630);
    wait_drained();

    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
